[rtl/core/cdq_pkg.sv]
// Package for the circular deque: sizes, command codes and the result
// status record passed from the pointer control to the top level.
// No dependencies.
`default_nettype none

package cdq_pkg;

   localparam int DEPTH   = 1024;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int WORD_W  = 32;
   localparam int CMD_W   = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5
   } cdq_cmd_type;

   typedef struct packed {
      logic             data_valid;
      logic             rejected;
      logic [CNT_W-1:0] count;
      logic             is_empty;
      logic             is_full;
   } cdq_status_type;

   typedef struct packed {
      logic             we;
      logic             re;
      logic [PTR_W-1:0] addr;
   } cdq_ram_ctl_type;

endpackage

`default_nettype wire

[rtl/core/cdq_if.sv]
// Valid/ready channel interfaces for the deque's command and result sides.
// Depends on cdq_pkg.
`default_nettype none

interface cdq_req_if
   import cdq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cdq_rsp_if
   import cdq_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] data;
   logic                     data_valid;
   logic                     rejected;
   logic [CNT_W-1:0]         count;
   logic                     is_empty;
   logic                     is_full;

   modport source (output valid, output data, output data_valid, output rejected,
                   output count, output is_empty, output is_full, input ready);
   modport sink   (input valid, input data, input data_valid, input rejected,
                   input count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

[rtl/core/circular_deque.sv]
// Top level of the circular deque: pointer control, ring store and the
// result register. Depends on cdq_pkg, cdq_if, cdq_ram and cdq_ctrl.
//
//   channel   | dir | handshake                  | payload
//   req_chan  | in  | valid/ready, accept v & r  | cmd, value
//   rsp_chan  | out | valid/ready, accept v & r  | data, data_valid, rejected,
//             |     |                            | count, is_empty, is_full
//
// One transaction per cycle unless the result stalls: a command is decoded and
// its store access issued in the cycle it is accepted; the store read and the
// status land in their registers, which present the result the next cycle.
// A stalled result holds in those registers and blocks new commands; a new
// command is taken in the same cycle the held result leaves.
// Synchronous reset sets the head pointer to one, clears the tail pointer, the
// count and the result valid; the store itself is not cleared (no sweep).
`default_nettype none

module circular_deque
   import cdq_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   cdq_req_if.sink   req_chan,
   cdq_rsp_if.source rsp_chan
);

   logic                  accept;
   cdq_ram_ctl_type       ram_ctl;
   cdq_status_type        status;
   logic [WORD_W-1:0]     rdata_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   cdq_status_type        rsp_status_ff;

   // the result register is free when empty or draining this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   cdq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_chan.cmd),
      .ram_ctl (ram_ctl),
      .status  (status)
   );

   // back-to-back push then pop of the same entry is safe: the write
   // completes at the edge before the read is issued
   cdq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH),
      .ADDR_W(PTR_W)
   ) u_ram (
      .clock   (clock),
      .we      (ram_ctl.we),
      .re      (ram_ctl.re),
      .addr    (ram_ctl.addr),
      .wdata   (WORD_W'(req_chan.value)),
      .rdata_ff(rdata_ff)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture the status with the transaction; the read word lands in the
   // store's own output register at the same edge
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.data       = rsp_status_ff.data_valid ? signed'(rdata_ff) : '0;
   assign rsp_chan.data_valid = rsp_status_ff.data_valid;
   assign rsp_chan.rejected   = rsp_status_ff.rejected;
   assign rsp_chan.count      = rsp_status_ff.count;
   assign rsp_chan.is_empty   = rsp_status_ff.is_empty;
   assign rsp_chan.is_full    = rsp_status_ff.is_full;

endmodule

`default_nettype wire

[rtl/core/cdq_ram.sv]
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module cdq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output      logic [WIDTH-1:0]  rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   // hold the last read word while no read is issued
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

`default_nettype wire

[rtl/core/cdq_ctrl.sv]
// Head, tail and count registers of the deque; decodes each command into a
// store access, if it needs one, and the status of its result. Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl
   import cdq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [CMD_W-1:0] cmd,
   output      cdq_ram_ctl_type  ram_ctl,
   output      cdq_status_type   status
);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             empty, full;
   logic [PTR_W-1:0] head_prev, head_next, tail_prev, tail_next;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= PTR_W'(1);
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == CNT_W'(DEPTH));
      head_prev = ring_prev(head_ff);
      head_next = ring_next(head_ff);
      tail_prev = ring_prev(tail_ff);
      tail_next = ring_next(tail_ff);

      head_in            = head_ff;
      tail_in            = tail_ff;
      count_in           = count_ff;
      ram_ctl.we         = 1'b0;
      ram_ctl.re         = 1'b0;
      ram_ctl.addr       = head_ff;
      status.data_valid  = 1'b0;
      status.rejected    = 1'b0;

      case (cdq_cmd_type'(cmd))
         CMD_PUSH_FRONT: begin
            if (full) begin
               status.rejected = 1'b1;
            end else begin
               head_in      = head_prev;
               ram_ctl.we   = accept;
               ram_ctl.addr = head_prev;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         CMD_PUSH_BACK: begin
            if (full) begin
               status.rejected = 1'b1;
            end else begin
               tail_in      = tail_next;
               ram_ctl.we   = accept;
               ram_ctl.addr = tail_next;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               status.rejected = 1'b1;
            end else begin
               head_in           = head_next;
               ram_ctl.re        = accept;
               ram_ctl.addr      = head_ff;
               status.data_valid = 1'b1;
               count_in          = count_ff - CNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (empty) begin
               status.rejected = 1'b1;
            end else begin
               tail_in           = tail_prev;
               ram_ctl.re        = accept;
               ram_ctl.addr      = tail_ff;
               status.data_valid = 1'b1;
               count_in          = count_ff - CNT_W'(1);
            end
         end
         CMD_PEEK_FRONT: begin
            if (empty) begin
               status.rejected = 1'b1;
            end else begin
               ram_ctl.re        = accept;
               ram_ctl.addr      = head_ff;
               status.data_valid = 1'b1;
            end
         end
         CMD_PEEK_BACK: begin
            if (empty) begin
               status.rejected = 1'b1;
            end else begin
               ram_ctl.re        = accept;
               ram_ctl.addr      = tail_ff;
               status.data_valid = 1'b1;
            end
         end
         default: begin
            // unused codes change nothing
         end
      endcase

      status.count    = count_in;
      status.is_empty = (count_in == '0);
      status.is_full  = (count_in == CNT_W'(DEPTH));
   end

endmodule

`default_nettype wire
